@@ rtl/core/assert_macros.svh @@
// assertion macros used by the rtl top level
// depends on nothing
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising edge outside reset
`define LOBM_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication checked at every rising edge outside reset
`define LOBM_ASSERT_IMP(lbl, clk, rst_n, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);

`endif

@@ rtl/core/lobm_pkg.sv @@
// constants and codes of the limit order book matcher
// depends on nothing
`timescale 1ns / 1ps
package lobm_pkg;
	localparam int COST_BITS = 48;
	localparam int LEVEL_AMT_BITS = 32;
	localparam logic [COST_BITS-1:0] COST_MAX = '1;
	localparam logic [LEVEL_AMT_BITS-1:0] LEVEL_AMT_MAX = '1;

	// order side codes
	localparam logic CMD_BUY = 1'b0;
	localparam logic CMD_SELL = 1'b1;

	// side table indexes
	localparam logic SIDE_BID = 1'b0;
	localparam logic SIDE_ASK = 1'b1;
endpackage

@@ rtl/core/lobm_if.sv @@
// valid/ready channel interfaces for orders and results
// depends on lobm_pkg
`timescale 1ns / 1ps
interface lobm_order_if #(
	parameter int PRICE_BITS = 16,
	parameter int AMOUNT_BITS = 24
);
	logic valid;
	logic ready;
	logic cmd;
	logic [PRICE_BITS-1:0] limit_price;
	logic [AMOUNT_BITS-1:0] order_amount;

	modport source (output valid, cmd, limit_price, order_amount, input ready);
	modport sink (input valid, cmd, limit_price, order_amount, output ready);
endinterface

interface lobm_result_if
	import lobm_pkg::*;
#(
	parameter int PRICE_BITS = 16,
	parameter int AMOUNT_BITS = 24
);
	logic valid;
	logic ready;
	logic [AMOUNT_BITS-1:0] executed_amount;
	logic [COST_BITS-1:0] total_cost;
	logic side_full;
	logic best_bid_valid;
	logic [PRICE_BITS-1:0] best_bid;
	logic best_ask_valid;
	logic [PRICE_BITS-1:0] best_ask;
	logic [PRICE_BITS-1:0] last_order_price;

	modport source (output valid, executed_amount, total_cost, side_full, best_bid_valid,
		best_bid, best_ask_valid, best_ask, last_order_price, input ready);
	modport sink (input valid, executed_amount, total_cost, side_full, best_bid_valid,
		best_bid, best_ask_valid, best_ask, last_order_price, output ready);
endinterface

@@ rtl/core/limit_order_book_matcher.sv @@
// limit order book matcher top level: fsm, level tables, result register
// depends on lobm_pkg, lobm_if, lobm_level_ram, assert_macros.svh
//
// usage: orders (side, limit price, amount) arrive on the order channel and
// one result per order leaves on the result channel, both valid/ready.
// each side of the book is a sorted circular table of price levels in its
// own ram with a registered read port. an order first walks the opposite
// side from the best level, reading and evaluating each level it fills and
// adding its cost, then rests any remainder: a sorted search that reads and
// evaluates each level passed, then either a merge into the level of equal
// price or, if the side has room, a shift of the worse levels, read and
// written one by one, and a write of the new level; last the best prices
// are read back. one order is in work at a time: the next one is taken
// only once the result of the last is in the output register.
// reset empties both tables at once through their counts; no clearing pass.
// a finished result sits in the output register; the next order is taken
// while it waits, but its own result holds until the receiver takes the
// first one.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module limit_order_book_matcher
	import lobm_pkg::*;
#(
	parameter int LEVELS = 64,
	parameter int PRICE_BITS = 16,
	parameter int AMOUNT_BITS = 24
) (
	input  logic clk,
	input  logic arst_n,
	lobm_order_if.sink order,
	lobm_result_if.source result
);
	localparam int IW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
	localparam int CW = $clog2(LEVELS + 1);
	localparam int EW = PRICE_BITS + LEVEL_AMT_BITS;
	localparam int PW = PRICE_BITS + AMOUNT_BITS;
	localparam logic [CW-1:0] LEVELS_C = CW'(LEVELS);

	typedef enum logic [3:0] {
		ST_IDLE, ST_M_RD, ST_M_EV, ST_M_ACC, ST_R_RD, ST_R_EV, ST_INS_CHK,
		ST_S_RD, ST_S_WR, ST_INS, ST_BEST_RD, ST_BEST_CAP
	} state_t;

	state_t state_q;
	logic cmd_q;
	logic [PRICE_BITS-1:0] price_q;
	logic [AMOUNT_BITS-1:0] amt_q, rem_q, done_q;
	logic [COST_BITS-1:0] cost_q;
	logic full_q;
	logic [CW-1:0] i_q, j_q;
	logic [IW-1:0] head_q [2];
	logic [CW-1:0] cnt_q [2];
	logic [PW-1:0] prod_s1;
	logic out_valid_q;

	logic ram_we [2];
	logic [IW-1:0] ram_waddr [2];
	logic [EW-1:0] ram_wdata [2];
	logic [IW-1:0] ram_raddr [2];
	logic [EW-1:0] ram_rdata [2];

	// logical level index to ram address on a circular table
	function automatic logic [IW-1:0] phys(input logic [IW-1:0] h, input logic [CW-1:0] i);
		logic [CW:0] s;
		s = (CW+1)'(h) + (CW+1)'(i);
		if (s >= (CW+1)'(LEVELS)) begin
			s = s - (CW+1)'(LEVELS);
		end
		return s[IW-1:0];
	endfunction

	// rams of both sides
	for (genvar s = 0; s < 2; s++) begin : g_side
		lobm_level_ram #(.DEPTH(LEVELS), .WIDTH(EW), .AW(IW)) u_ram (
			.clk(clk),
			.we(ram_we[s]),
			.waddr(ram_waddr[s]),
			.wdata(ram_wdata[s]),
			.raddr(ram_raddr[s]),
			.rdata(ram_rdata[s])
		);
	end

	// side selection: match against the opposite side, rest on the own side
	logic ms, rs;
	assign ms = ~cmd_q;
	assign rs = cmd_q;

	logic [PRICE_BITS-1:0] m_lp, r_lp;
	logic [LEVEL_AMT_BITS-1:0] m_la, r_la, rem_ext;
	logic m_cross, m_whole, r_better;
	logic [AMOUNT_BITS-1:0] fill;
	logic [LEVEL_AMT_BITS:0] merge_sum;
	logic [LEVEL_AMT_BITS-1:0] merge_amt;

	assign m_lp = ram_rdata[ms][EW-1:LEVEL_AMT_BITS];
	assign m_la = ram_rdata[ms][LEVEL_AMT_BITS-1:0];
	assign r_lp = ram_rdata[rs][EW-1:LEVEL_AMT_BITS];
	assign r_la = ram_rdata[rs][LEVEL_AMT_BITS-1:0];
	assign rem_ext = LEVEL_AMT_BITS'(rem_q);

	// crossing test and fill of the level at the head
	assign m_cross = (cmd_q == CMD_BUY) ? (m_lp <= price_q) : (m_lp >= price_q);
	assign m_whole = (m_la <= rem_ext);
	assign fill = m_whole ? AMOUNT_BITS'(m_la) : rem_q;

	// sort order of the resting side: bids descending, asks ascending
	assign r_better = (rs == SIDE_BID) ? (r_lp > price_q) : (r_lp < price_q);

	// saturating merge into an existing level
	assign merge_sum = (LEVEL_AMT_BITS+1)'(r_la) + (LEVEL_AMT_BITS+1)'(rem_ext);
	assign merge_amt = merge_sum[LEVEL_AMT_BITS] ? LEVEL_AMT_MAX
		: merge_sum[LEVEL_AMT_BITS-1:0];

	// ram port control
	always_comb begin
		for (int s = 0; s < 2; s++) begin
			ram_raddr[s] = phys(head_q[s], '0);
			ram_we[s] = 1'b0;
			ram_waddr[s] = '0;
			ram_wdata[s] = '0;
		end
		unique case (state_q)
			ST_M_EV: begin
				if (m_cross && !m_whole) begin
					ram_we[ms] = 1'b1;
					ram_waddr[ms] = phys(head_q[ms], '0);
					ram_wdata[ms] = {m_lp, m_la - LEVEL_AMT_BITS'(fill)};
				end
			end
			ST_R_RD: ram_raddr[rs] = phys(head_q[rs], i_q);
			ST_R_EV: begin
				if (i_q < cnt_q[rs] && r_lp == price_q) begin
					ram_we[rs] = 1'b1;
					ram_waddr[rs] = phys(head_q[rs], i_q);
					ram_wdata[rs] = {r_lp, merge_amt};
				end
			end
			ST_S_RD: ram_raddr[rs] = phys(head_q[rs], j_q - CW'(1));
			ST_S_WR: begin
				ram_we[rs] = 1'b1;
				ram_waddr[rs] = phys(head_q[rs], j_q);
				ram_wdata[rs] = ram_rdata[rs];
			end
			ST_INS: begin
				ram_we[rs] = 1'b1;
				ram_waddr[rs] = phys(head_q[rs], i_q);
				ram_wdata[rs] = {price_q, rem_ext};
			end
			default: ;
		endcase
	end

	// saturating cost accumulation
	logic [63:0] cost_room;
	logic [COST_BITS-1:0] cost_next;
	assign cost_room = 64'(COST_MAX - cost_q);
	assign cost_next = (64'(prod_s1) > cost_room) ? COST_MAX : cost_q + COST_BITS'(prod_s1);

	// result capture when the output register is free or being emptied
	logic cap_fire;
	assign cap_fire = (state_q == ST_BEST_CAP) && (!out_valid_q || result.ready);

	assign order.ready = (state_q == ST_IDLE);
	assign result.valid = out_valid_q;

	// order sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
			for (int s = 0; s < 2; s++) begin
				head_q[s] <= '0;
				cnt_q[s] <= '0;
			end
			cmd_q <= CMD_BUY;
			price_q <= '0;
			amt_q <= '0;
			rem_q <= '0;
			done_q <= '0;
			cost_q <= '0;
			full_q <= 1'b0;
			i_q <= '0;
			j_q <= '0;
			prod_s1 <= '0;
			result.executed_amount <= '0;
			result.total_cost <= '0;
			result.side_full <= 1'b0;
			result.best_bid_valid <= 1'b0;
			result.best_bid <= '0;
			result.best_ask_valid <= 1'b0;
			result.best_ask <= '0;
			result.last_order_price <= '0;
		end else begin
			if (cap_fire) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && result.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (order.valid) begin
						cmd_q <= order.cmd;
						price_q <= order.limit_price;
						amt_q <= order.order_amount;
						rem_q <= order.order_amount;
						done_q <= '0;
						cost_q <= '0;
						full_q <= 1'b0;
						state_q <= ST_M_RD;
					end
				end
				ST_M_RD: begin
					if (rem_q == '0 || cnt_q[ms] == '0) begin
						i_q <= '0;
						state_q <= ST_R_RD;
					end else begin
						state_q <= ST_M_EV;
					end
				end
				ST_M_EV: begin
					if (m_cross) begin
						prod_s1 <= PW'(m_lp) * PW'(fill);
						rem_q <= rem_q - fill;
						done_q <= done_q + fill;
						if (m_whole) begin
							head_q[ms] <= phys(head_q[ms], CW'(1));
							cnt_q[ms] <= cnt_q[ms] - CW'(1);
						end
						state_q <= ST_M_ACC;
					end else begin
						i_q <= '0;
						state_q <= ST_R_RD;
					end
				end
				ST_M_ACC: begin
					cost_q <= cost_next;
					state_q <= ST_M_RD;
				end
				ST_R_RD: begin
					if (rem_q == '0) begin
						state_q <= ST_BEST_RD;
					end else if (i_q >= cnt_q[rs]) begin
						state_q <= ST_INS_CHK;
					end else begin
						state_q <= ST_R_EV;
					end
				end
				ST_R_EV: begin
					if (r_lp == price_q) begin
						state_q <= ST_BEST_RD;
					end else if (r_better) begin
						i_q <= i_q + CW'(1);
						state_q <= ST_R_RD;
					end else begin
						state_q <= ST_INS_CHK;
					end
				end
				ST_INS_CHK: begin
					if (cnt_q[rs] >= LEVELS_C) begin
						full_q <= 1'b1;
						state_q <= ST_BEST_RD;
					end else begin
						j_q <= cnt_q[rs];
						state_q <= ST_S_RD;
					end
				end
				ST_S_RD: begin
					state_q <= (j_q == i_q) ? ST_INS : ST_S_WR;
				end
				ST_S_WR: begin
					j_q <= j_q - CW'(1);
					state_q <= ST_S_RD;
				end
				ST_INS: begin
					cnt_q[rs] <= cnt_q[rs] + CW'(1);
					state_q <= ST_BEST_RD;
				end
				ST_BEST_RD: state_q <= ST_BEST_CAP;
				ST_BEST_CAP: begin
					if (cap_fire) begin
						result.executed_amount <= done_q;
						result.total_cost <= cost_q;
						result.side_full <= full_q;
						result.best_bid_valid <= (cnt_q[SIDE_BID] != '0);
						result.best_bid <= (cnt_q[SIDE_BID] != '0)
							? ram_rdata[SIDE_BID][EW-1:LEVEL_AMT_BITS] : '0;
						result.best_ask_valid <= (cnt_q[SIDE_ASK] != '0);
						result.best_ask <= (cnt_q[SIDE_ASK] != '0)
							? ram_rdata[SIDE_ASK][EW-1:LEVEL_AMT_BITS] : '0;
						result.last_order_price <= price_q;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// checks
	`LOBM_ASSERT(a_bid_cnt, clk, arst_n, cnt_q[SIDE_BID] <= LEVELS_C, "bid level count overflow")
	`LOBM_ASSERT(a_ask_cnt, clk, arst_n, cnt_q[SIDE_ASK] <= LEVELS_C, "ask level count overflow")
	`LOBM_ASSERT_IMP(a_conserve, clk, arst_n, state_q != ST_IDLE,
		(AMOUNT_BITS+1)'(done_q) + (AMOUNT_BITS+1)'(rem_q) == (AMOUNT_BITS+1)'(amt_q),
		"executed plus remainder differs from order amount")
	`LOBM_ASSERT_IMP(a_shift_range, clk, arst_n, state_q == ST_S_WR, j_q > i_q,
		"level shift below insert position")
endmodule

@@ rtl/core/lobm_level_ram.sv @@
// price level memory: one write port, one registered read port
// depends on nothing
`timescale 1ns / 1ps
module lobm_level_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 48,
	parameter int AW = 6
) (
	input  logic clk,
	input  logic we,
	input  logic [AW-1:0] waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end
endmodule

@@ sim/lobm_book_checker.sv @@
// checker for the limit order book matcher: predicts each order's result
// depends on lobm_pkg and lobm_if (watches both channels, never drives them)
`timescale 1ns / 1ps
module lobm_book_checker
	import lobm_pkg::*;
#(
	parameter int LEVELS = 64,
	parameter int PRICE_BITS = 16,
	parameter int AMOUNT_BITS = 24
) (
	input  logic clk,
	input  logic arst_n,
	lobm_order_if.sink order,
	lobm_result_if.sink result,
	output int fail_count,
	output int pending_count
);
	typedef struct packed {
		logic [AMOUNT_BITS-1:0] executed_amount;
		logic [COST_BITS-1:0] total_cost;
		logic side_full;
		logic best_bid_valid;
		logic [PRICE_BITS-1:0] best_bid;
		logic best_ask_valid;
		logic [PRICE_BITS-1:0] best_ask;
		logic [PRICE_BITS-1:0] last_order_price;
	} book_result_t;

	// shadow book: index 0 is the best level on each side
	logic [PRICE_BITS-1:0] bid_px[$];
	logic [LEVEL_AMT_BITS-1:0] bid_qty[$];
	logic [PRICE_BITS-1:0] ask_px[$];
	logic [LEVEL_AMT_BITS-1:0] ask_qty[$];
	book_result_t expected_results[$];

	assign pending_count = expected_results.size();

	// match, rest the remainder, report the book top
	function automatic book_result_t apply_order(logic sell, logic [PRICE_BITS-1:0] px,
		logic [AMOUNT_BITS-1:0] qty);
		book_result_t r;
		logic [63:0] rem, fill, prod, cost, sum;
		int pos;
		r = '0;
		rem = qty;
		cost = 0;
		r.last_order_price = px;
		// walk the opposite side while it crosses
		while (rem > 0) begin
			if (sell ? bid_px.size() == 0 : ask_px.size() == 0) break;
			if (sell ? bid_px[0] < px : ask_px[0] > px) break;
			fill = sell ? bid_qty[0] : ask_qty[0];
			if (fill > rem) fill = rem;
			rem -= fill;
			r.executed_amount += fill[AMOUNT_BITS-1:0];
			prod = (sell ? bid_px[0] : ask_px[0]) * fill;
			if (prod > COST_MAX - cost) cost = COST_MAX;
			else cost += prod;
			if (sell) begin
				bid_qty[0] -= fill[LEVEL_AMT_BITS-1:0];
				if (bid_qty[0] == 0) begin
					void'(bid_px.pop_front());
					void'(bid_qty.pop_front());
				end
			end else begin
				ask_qty[0] -= fill[LEVEL_AMT_BITS-1:0];
				if (ask_qty[0] == 0) begin
					void'(ask_px.pop_front());
					void'(ask_qty.pop_front());
				end
			end
		end
		r.total_cost = cost[COST_BITS-1:0];
		// rest any remainder on the own side
		if (rem > 0) begin
			pos = 0;
			if (!sell) begin
				while (pos < bid_px.size() && bid_px[pos] > px) pos++;
				if (pos < bid_px.size() && bid_px[pos] == px) begin
					sum = bid_qty[pos] + rem;
					bid_qty[pos] = (sum > LEVEL_AMT_MAX) ? LEVEL_AMT_MAX
						: sum[LEVEL_AMT_BITS-1:0];
				end else if (bid_px.size() >= LEVELS) r.side_full = 1'b1;
				else begin
					bid_px.insert(pos, px);
					bid_qty.insert(pos, rem[LEVEL_AMT_BITS-1:0]);
				end
			end else begin
				while (pos < ask_px.size() && ask_px[pos] < px) pos++;
				if (pos < ask_px.size() && ask_px[pos] == px) begin
					sum = ask_qty[pos] + rem;
					ask_qty[pos] = (sum > LEVEL_AMT_MAX) ? LEVEL_AMT_MAX
						: sum[LEVEL_AMT_BITS-1:0];
				end else if (ask_px.size() >= LEVELS) r.side_full = 1'b1;
				else begin
					ask_px.insert(pos, px);
					ask_qty.insert(pos, rem[LEVEL_AMT_BITS-1:0]);
				end
			end
		end
		r.best_bid_valid = bid_px.size() > 0;
		if (r.best_bid_valid) r.best_bid = bid_px[0];
		r.best_ask_valid = ask_px.size() > 0;
		if (r.best_ask_valid) r.best_ask = ask_px[0];
		return r;
	endfunction

	// watch both channels at each rising edge
	always @(posedge clk or negedge arst_n) begin
		book_result_t got, exp_r;
		if (!arst_n) begin
			fail_count <= 0;
		end else begin
			if (order.valid && order.ready)
				expected_results.insert(expected_results.size(),
					apply_order(order.cmd, order.limit_price, order.order_amount));
			if (result.valid && result.ready) begin
				got = '{result.executed_amount, result.total_cost, result.side_full,
					result.best_bid_valid, result.best_bid, result.best_ask_valid,
					result.best_ask, result.last_order_price};
				if (expected_results.size() == 0) begin
					if (fail_count < 10) $display("result with no order pending: %p", got);
					fail_count <= fail_count + 1;
				end else begin
					exp_r = expected_results.pop_front();
					if (got !== exp_r) begin
						if (fail_count < 10) $display("mismatch: expected %p actual %p", exp_r, got);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end
endmodule

@@ sim/tb_limit_order_book_matcher.sv @@
// testbench top for the limit order book matcher: clock, reset, orders, verdict
// depends on lobm_pkg, lobm_if, limit_order_book_matcher, lobm_book_checker
`timescale 1ns / 1ps
module tb_limit_order_book_matcher
	import lobm_pkg::*;
();

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int fail_count, pending_count;
	int cycle_count = 0;
	bit quiet_tail = 0;

	lobm_order_if order ();
	lobm_result_if result ();

	limit_order_book_matcher dut (.clk(clk), .arst_n(arst_n), .order(order), .result(result));
	lobm_book_checker checker_i (.clk(clk), .arst_n(arst_n), .order(order), .result(result),
		.fail_count(fail_count), .pending_count(pending_count));

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// cycle limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 4000000) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// receiver with random stall bursts
	initial begin
		int stall;
		result.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!quiet_tail && $urandom_range(0, 5) == 0) begin
				stall = $urandom_range(1, 6);
				result.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			result.ready <= 1'b1;
		end
	end

	// send one transaction, with an occasional idle burst first
	task automatic send_order(logic side, logic [15:0] px, logic [23:0] qty);
		if (!quiet_tail && $urandom_range(0, 4) == 0) begin
			order.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		order.valid <= 1'b1;
		order.cmd <= side;
		order.limit_price <= px;
		order.order_amount <= qty;
		do @(posedge clk); while (!order.ready);
		@(negedge clk);
	endtask

	// price close to a moving center so levels cross and merge often
	function automatic logic [15:0] near_price(int center);
		int p;
		p = center + $signed($urandom_range(0, 40)) - 20;
		if (p < 0) p = 0;
		if (p > 65535) p = 65535;
		return p[15:0];
	endfunction

	function automatic logic [23:0] rand_qty();
		unique case ($urandom_range(0, 9))
			0: return 24'd0;
			1: return 24'hFFFFFF;
			2: return 24'($urandom);
			default: return 24'($urandom_range(1, 500));
		endcase
	endfunction

	initial begin
		int center;
		order.valid = 1'b0;
		order.cmd = CMD_BUY;
		order.limit_price = '0;
		order.order_amount = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: extremes, zero amount, crossing, merge saturation
		send_order(CMD_BUY, 16'd0, 24'd0);
		send_order(CMD_SELL, 16'hFFFF, 24'd0);
		send_order(CMD_BUY, 16'd100, 24'd50);
		send_order(CMD_BUY, 16'd100, 24'd20);
		send_order(CMD_BUY, 16'd120, 24'd10);
		send_order(CMD_SELL, 16'd90, 24'd40);
		send_order(CMD_SELL, 16'd130, 24'd5);
		send_order(CMD_BUY, 16'd200, 24'd100);
		send_order(CMD_SELL, 16'd0, 24'hFFFFFF);
		send_order(CMD_BUY, 16'hFFFF, 24'hFFFFFF);
		for (int i = 0; i < 300; i++) send_order(CMD_BUY, 16'h5555, 24'hFFFFFF);
		send_order(CMD_SELL, 16'hFFFF, 24'h00AAAA);
		send_order(CMD_SELL, 16'h0000, 24'hFFFFFF);
		send_order(CMD_SELL, 16'hAAAA, 24'h555555);

		// pause until every result has come
		order.valid <= 1'b0;
		while (pending_count != 0) @(negedge clk);

		// 66 small sells at rising prices, which cross the resting bid, then a buy at the top price
		for (int i = 0; i < 66; i++) send_order(CMD_SELL, 16'd1000 + 16'(i), 24'd3);
		send_order(CMD_BUY, 16'hFFFF, 24'd1000);

		// random: book-building around a drifting center, some noise
		center = 30000;
		for (int i = 0; i < 770; i++) begin
			if (i == 670) quiet_tail = 1;
			if ($urandom_range(0, 49) == 0) center = $urandom_range(100, 65435);
			if ($urandom_range(0, 9) == 0)
				send_order(1'($urandom_range(0, 1)), 16'($urandom), 24'($urandom));
			else
				send_order(1'($urandom_range(0, 1)), near_price(center), rand_qty());
		end
		order.valid <= 1'b0;

		while (pending_count != 0) @(negedge clk);
		repeat (400) @(negedge clk);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule

@@ limit_order_book_matcher.f @@
+incdir+rtl/core
rtl/core/lobm_pkg.sv
rtl/core/lobm_if.sv
rtl/core/lobm_level_ram.sv
rtl/core/limit_order_book_matcher.sv
sim/lobm_book_checker.sv
sim/tb_limit_order_book_matcher.sv
